// ===== rtl/rqfs_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none

package rqfs_pkg;

	localparam int QUEUE_DEPTH_DEF = 16;
	localparam int FUNC_W = 2;
	localparam int ID_W = 8;
	localparam int TIME_W = 16;
	localparam int OCC_W = 5;

	localparam logic [FUNC_W-1:0] OP_APPEND = 2'd0;
	localparam logic [FUNC_W-1:0] OP_SORTED = 2'd1;
	localparam logic [FUNC_W-1:0] OP_POP = 2'd2;

	typedef struct packed {
		logic [ID_W-1:0] id;
		logic [TIME_W-1:0] svc;
		logic [TIME_W-1:0] arr;
	} entry_t;

	// Broadcast to every cell in the chain.
	typedef struct packed {
		logic ins_en;
		logic pop_en;
		logic sorted;
	} cell_ctrl_t;

	// True when a new entry belongs in front of a stored one.
	function automatic logic goes_before(input entry_t nw, input entry_t cur);
		goes_before = (nw.svc < cur.svc) || ((nw.svc == cur.svc) && (nw.arr <= cur.arr));
	endfunction

endpackage

`default_nettype wire

// ===== rtl/rqfs_if.sv =====
`timescale 1ns / 1ps
`default_nettype none

interface rqfs_req_if import rqfs_pkg::*; ();
	logic valid;
	logic ready;
	logic [FUNC_W-1:0] func;
	logic [ID_W-1:0] proc_id;
	logic [TIME_W-1:0] service_time;
	logic [TIME_W-1:0] arrival_time;

	modport source (output valid, func, proc_id, service_time, arrival_time, input ready);
	modport sink (input valid, func, proc_id, service_time, arrival_time, output ready);
endinterface

interface rqfs_rsp_if import rqfs_pkg::*; ();
	logic valid;
	logic ready;
	logic pop_valid;
	logic [ID_W-1:0] out_proc_id;
	logic [TIME_W-1:0] out_service_time;
	logic [TIME_W-1:0] out_arrival_time;
	logic overflow;
	logic [OCC_W-1:0] occupancy;

	modport source (output valid, pop_valid, out_proc_id, out_service_time, out_arrival_time,
		overflow, occupancy, input ready);
	modport sink (input valid, pop_valid, out_proc_id, out_service_time, out_arrival_time,
		overflow, occupancy, output ready);
endinterface

`default_nettype wire

// ===== rtl/rqfs_cell.sv =====
`timescale 1ns / 1ps
`default_nettype none

module rqfs_cell import rqfs_pkg::*; #(
	parameter int QUEUE_DEPTH = QUEUE_DEPTH_DEF,
	parameter int IDX = 0,
	localparam int CW = $clog2(QUEUE_DEPTH + 1)
) (
	input wire logic clk,
	input wire cell_ctrl_t ctrl,
	input wire logic [CW-1:0] count,
	input wire entry_t new_entry,
	input wire entry_t left_entry,
	input wire entry_t right_entry,
	input wire logic found_in,
	output logic found_out,
	output entry_t entry
);

	entry_t entry_q;
	logic occ;
	logic tail;
	logic hit;

	assign occ = count > CW'(IDX);
	assign tail = count == CW'(IDX);
	assign hit = ctrl.sorted && occ && goes_before(new_entry, entry_q);
	// insertion point found here or upstream
	assign found_out = found_in || hit || tail;
	assign entry = entry_q;

	always_ff @(posedge clk) begin
		if (ctrl.ins_en) begin
			if (found_in) begin
				entry_q <= left_entry;
			end else if (hit || tail) begin
				entry_q <= new_entry;
			end
		end else if (ctrl.pop_en) begin
			entry_q <= right_entry;
		end
	end

endmodule

`default_nettype wire

// ===== rtl/ready_queue_fifo_and_sorted.sv =====
`timescale 1ns / 1ps
`default_nettype none

// Bounded process ready queue built as a chain of QUEUE_DEPTH entry cells, head in
// cell 0. Each req item carries func: append at the tail, sorted insert (ahead of the
// first entry with a larger service time, or an equal service time and an equal or
// larger arrival time), or pop head. Every item yields exactly one rsp item in the cycle
// after acceptance: the popped entry with pop_valid (all out_ fields zero otherwise),
// an overflow flag when an insert hit a full queue and was dropped, and the occupancy
// after the operation (low 5 bits of the count). One item is accepted per cycle; req
// ready drops only while a result waits in the output register and rsp is not taking
// it. All cells compare against the new entry at once and shift together; the
// clock period is set by the priority chain that locates the insertion point, rippling
// through every cell. Entry storage needs no clearing after reset.
module ready_queue_fifo_and_sorted import rqfs_pkg::*; #(
	parameter int QUEUE_DEPTH = QUEUE_DEPTH_DEF
) (
	input wire logic clk,
	input wire logic arst_n,
	rqfs_req_if.sink req,
	rqfs_rsp_if.source rsp
);

	localparam int CW = $clog2(QUEUE_DEPTH + 1);

	logic [CW-1:0] count_q;
	logic [CW-1:0] count_next;
	logic accept;
	logic is_ins;
	logic full;
	logic empty;
	cell_ctrl_t ctrl;
	entry_t new_entry;
	entry_t entries [QUEUE_DEPTH];
	logic found [QUEUE_DEPTH+1];
	logic [31:0] count_ext;

	logic valid_q;
	logic pop_valid_q;
	entry_t out_q;
	logic overflow_q;
	logic [OCC_W-1:0] occ_q;

	// Output register frees up when rsp takes it, so a new item may enter the same cycle.
	assign req.ready = !valid_q || rsp.ready;
	assign accept = req.valid && req.ready;

	assign is_ins = (req.func == OP_APPEND) || (req.func == OP_SORTED);
	assign full = count_q == CW'(QUEUE_DEPTH);
	assign empty = count_q == '0;

	assign ctrl.ins_en = accept && is_ins && !full;
	assign ctrl.pop_en = accept && (req.func == OP_POP) && !empty;
	assign ctrl.sorted = req.func == OP_SORTED;

	assign new_entry.id = req.proc_id;
	assign new_entry.svc = req.service_time;
	assign new_entry.arr = req.arrival_time;

	always_comb begin
		priority if (ctrl.ins_en) begin
			count_next = count_q + CW'(1);
		end else if (ctrl.pop_en) begin
			count_next = count_q - CW'(1);
		end else begin
			count_next = count_q;
		end
	end

	assign count_ext = 32'(count_next);

	// Cell chain: cell 0 has nothing upstream, the last cell nothing downstream.
	assign found[0] = 1'b0;

	for (genvar i = 0; i < QUEUE_DEPTH; i++) begin : g_cell
		entry_t left_e;
		entry_t right_e;

		if (i == 0) begin : g_head
			assign left_e = new_entry;
		end else begin : g_mid
			assign left_e = entries[i-1];
		end

		if (i == QUEUE_DEPTH - 1) begin : g_last
			assign right_e = entries[i];
		end else begin : g_next
			assign right_e = entries[i+1];
		end

		rqfs_cell #(
			.QUEUE_DEPTH(QUEUE_DEPTH),
			.IDX(i)
		) u_cell (
			.clk(clk),
			.ctrl(ctrl),
			.count(count_q),
			.new_entry(new_entry),
			.left_entry(left_e),
			.right_entry(right_e),
			.found_in(found[i]),
			.found_out(found[i+1]),
			.entry(entries[i])
		);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q <= '0;
			valid_q <= 1'b0;
		end else begin
			count_q <= count_next;
			if (accept) begin
				valid_q <= 1'b1;
			end else if (rsp.ready) begin
				valid_q <= 1'b0;
			end
		end
	end

	// result payload
	always_ff @(posedge clk) begin
		if (accept) begin
			pop_valid_q <= ctrl.pop_en;
			out_q <= ctrl.pop_en ? entries[0] : '0;
			overflow_q <= is_ins && full;
			occ_q <= count_ext[OCC_W-1:0];
		end
	end

	assign rsp.valid = valid_q;
	assign rsp.pop_valid = pop_valid_q;
	assign rsp.out_proc_id = out_q.id;
	assign rsp.out_service_time = out_q.svc;
	assign rsp.out_arrival_time = out_q.arr;
	assign rsp.overflow = overflow_q;
	assign rsp.occupancy = occ_q;

endmodule

`default_nettype wire

// ===== rtl/rqfs_checker.sv =====
`timescale 1ns / 1ps
`default_nettype none

module rqfs_checker import rqfs_pkg::*; (
	input wire logic clk,
	input wire logic arst_n,
	input wire logic req_valid,
	input wire logic req_ready,
	input wire logic rsp_valid,
	input wire logic rsp_ready,
	input wire logic pop_valid,
	input wire logic [ID_W-1:0] out_proc_id,
	input wire logic [TIME_W-1:0] out_service_time,
	input wire logic [TIME_W-1:0] out_arrival_time,
	input wire logic overflow,
	input wire logic [OCC_W-1:0] occupancy
);

	// stalled result holds
	a_rsp_hold: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && !rsp_ready |=> rsp_valid && $stable(pop_valid) && $stable(out_proc_id)
			&& $stable(out_service_time) && $stable(out_arrival_time)
			&& $stable(overflow) && $stable(occupancy))
		else $error("rsp payload changed under stall");

	// every accepted item gives a result next cycle
	a_one_result: assert property (@(posedge clk) disable iff (!arst_n)
		req_valid && req_ready |=> rsp_valid)
		else $error("accepted item produced no result");

	// nothing stalls the input unless a result is waiting
	a_ready: assert property (@(posedge clk) disable iff (!arst_n)
		!rsp_valid |-> req_ready)
		else $error("req stalled with empty output");

	a_excl: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid |-> !(pop_valid && overflow))
		else $error("pop and overflow together");

	a_zero: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && !pop_valid |-> out_proc_id == '0 && out_service_time == '0
			&& out_arrival_time == '0)
		else $error("non-pop result carries entry data");

endmodule

bind ready_queue_fifo_and_sorted rqfs_checker u_rqfs_checker (
	.clk(clk),
	.arst_n(arst_n),
	.req_valid(req.valid),
	.req_ready(req.ready),
	.rsp_valid(rsp.valid),
	.rsp_ready(rsp.ready),
	.pop_valid(rsp.pop_valid),
	.out_proc_id(rsp.out_proc_id),
	.out_service_time(rsp.out_service_time),
	.out_arrival_time(rsp.out_arrival_time),
	.overflow(rsp.overflow),
	.occupancy(rsp.occupancy)
);

`default_nettype wire
